[rtl/ffba_pkg.sv]
package ffba_pkg;

    localparam int ACTION_W = 2;
    localparam int ADDR_W   = 16;
    localparam int SIZE_W   = 17;

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_RESIZE  = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [20:0] {
        ST_IDLE     = 21'h000001,
        ST_FIND_RD  = 21'h000002,
        ST_FIND_CHK = 21'h000004,
        ST_GRANT_RD = 21'h000008,
        ST_GRANT_CK = 21'h000010,
        ST_DISPATCH = 21'h000020,
        ST_RZ_NRD   = 21'h000040,
        ST_RZ_NCHK  = 21'h000080,
        ST_SPLIT    = 21'h000100,
        ST_SPLIT_NX = 21'h000200,
        ST_GROW     = 21'h000400,
        ST_REL_PRD  = 21'h000800,
        ST_REL_PCK  = 21'h001000,
        ST_REL_ABS  = 21'h002000,
        ST_ABS_RD   = 21'h004000,
        ST_ABS_CK   = 21'h008000,
        ST_ABS_FIX  = 21'h010000,
        ST_REL_NX   = 21'h020000,
        ST_TRIM_RD  = 21'h040000,
        ST_TRIM     = 21'h080000,
        ST_OUT      = 21'h100000
    } state_t;

    typedef enum logic [2:0] {
        RET_GRANT,
        RET_RZ_SHRINK,
        RET_RZ_GROW,
        RET_REL1,
        RET_REL2,
        RET_MOVED
    } ret_t;

endpackage

[rtl/first_fit_block_allocator.sv]
// Channel  | Ports                      | Contents
// s_axis   | s_axis_tvalid/tready/tdata | action[1:0], address[17:2], size[33:18]
// m_axis   | m_axis_tvalid/tready/tdata | result_address[15:0], ok[16], moved[17]
// One item at a time; a request walks the address-ordered block chain in the
// table memory, reading and then checking each entry; a resize that moves
// walks it once to find the block and again to find a new place for it.
// Reset clears the slot map, chain head and heap top; the table needs no clear.
// The result is held in an output register until taken; the next item is
// accepted once that result has been taken.
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int HEADER_BYTES = 20,
    parameter int HEAP_BYTES   = 65536,
    parameter int MAX_BLOCKS   = 64
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // action, address, size, zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // result_address, ok, moved, zero fill
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int NW = $clog2(MAX_BLOCKS + 1);
    localparam logic [NW-1:0] NIL = NW'(MAX_BLOCKS);
    localparam logic [SIZE_W-1:0] HDR = SIZE_W'(HEADER_BYTES);
    localparam logic [SIZE_W-1:0] MINSPLIT = SIZE_W'(HEADER_BYTES + 4);
    localparam logic [SIZE_W:0] HEAP_LIM = (SIZE_W+1)'(HEAP_BYTES);

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] size;
        logic              free;
        logic [NW-1:0]     next;
        logic [NW-1:0]     prev;
    } ent_t;

    ent_t mem [MAX_BLOCKS];
    ent_t rd_q;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    ent_t          wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_q <= mem[rd_addr];
    end

    state_t state_reg, state_next;
    ret_t ret_reg, ret_next;
    logic [MAX_BLOCKS-1:0] used_reg, used_next;
    logic [NW-1:0] head_reg, head_next;
    logic [SIZE_W-1:0] top_reg, top_next;
    action_t act_reg, act_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [SIZE_W-1:0] s_reg, s_next;
    logic [NW-1:0] cur_reg, cur_next, last_reg, last_next;
    logic [NW:0] steps_reg, steps_next;
    ent_t b_reg, b_next, n_reg, n_next;
    logic [NW-1:0] bi_reg, bi_next, ni_reg, ni_next;
    logic [NW-1:0] oldi_reg, oldi_next;
    ent_t old_reg, old_next;
    logic [NW-1:0] fix_reg, fix_next;
    logic [ADDR_W-1:0] res_reg, res_next;
    logic ok_reg, ok_next, mv_reg, mv_next, ov_reg, ov_next;

    logic [NW-1:0] free_slot;
    logic          slot_avail;

    always_comb
    begin
        free_slot = NIL;
        for (int i = MAX_BLOCKS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_slot = NW'(i);
            end
        end
        slot_avail = (free_slot != NIL);
    end

    assign s_axis_tready = (state_reg == ST_IDLE) && !ov_reg;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata = {6'd0, mv_reg, ok_reg, res_reg};

    always_comb
    begin
        logic [SIZE_W:0] sum;
        logic [SIZE_W-1:0] rs;
        state_next = state_reg;
        ret_next = ret_reg;
        used_next = used_reg;
        head_next = head_reg;
        top_next = top_reg;
        act_next = act_reg;
        addr_next = addr_reg;
        s_next = s_reg;
        cur_next = cur_reg;
        last_next = last_reg;
        steps_next = steps_reg;
        b_next = b_reg;
        n_next = n_reg;
        bi_next = bi_reg;
        ni_next = ni_reg;
        oldi_next = oldi_reg;
        old_next = old_reg;
        fix_next = fix_reg;
        res_next = res_reg;
        ok_next = ok_reg;
        mv_next = mv_reg;
        ov_next = ov_reg;
        rd_addr = cur_reg[IW-1:0];
        wr_en = 1'b0;
        wr_addr = bi_reg[IW-1:0];
        wr_data = b_reg;
        sum = '0;
        rs = '0;
        if (ov_reg && m_axis_tready)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    act_next = action_t'(s_axis_tdata[1:0]);
                    addr_next = s_axis_tdata[17:2];
                    rs = {1'b0, s_axis_tdata[33:18]} + SIZE_W'(3);
                    s_next = {rs[SIZE_W-1:2], 2'b00};
                    res_next = '0;
                    ok_next = 1'b0;
                    mv_next = 1'b0;
                    cur_next = head_reg;
                    last_next = NIL;
                    steps_next = '0;
                    case (action_t'(s_axis_tdata[1:0]))
                        ACT_ALLOC:
                        begin
                            ret_next = RET_GRANT;
                            state_next = ST_GRANT_RD;
                        end
                        ACT_RELEASE, ACT_RESIZE:
                        begin
                            if (s_axis_tdata[17:2] == '0)
                            begin
                                if (action_t'(s_axis_tdata[1:0]) == ACT_RESIZE)
                                begin
                                    ret_next = RET_GRANT;
                                    state_next = ST_GRANT_RD;
                                end
                                else
                                begin
                                    state_next = ST_OUT;
                                end
                            end
                            else
                            begin
                                state_next = ST_FIND_RD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_FIND_RD:
            begin
                if (cur_reg >= NIL || steps_reg >= (NW+1)'(MAX_BLOCKS))
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    rd_addr = cur_reg[IW-1:0];
                    state_next = ST_FIND_CHK;
                end
            end
            ST_FIND_CHK:
            begin
                if ({1'b0, rd_q.start} + HDR == {1'b0, addr_reg})
                begin
                    if (rd_q.free)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        b_next = rd_q;
                        bi_next = cur_reg;
                        oldi_next = cur_reg;
                        old_next = rd_q;
                        state_next = ST_DISPATCH;
                    end
                end
                else
                begin
                    cur_next = rd_q.next;
                    steps_next = steps_reg + 1'b1;
                    state_next = ST_FIND_RD;
                end
            end
            ST_DISPATCH:
            begin
                if (act_reg == ACT_RELEASE)
                begin
                    ok_next = 1'b1;
                    ret_next = RET_REL1;
                    b_next.free = 1'b1;
                    state_next = ST_REL_PRD;
                end
                else if (b_reg.size >= s_reg)
                begin
                    res_next = addr_reg;
                    ok_next = 1'b1;
                    ret_next = RET_RZ_SHRINK;
                    state_next = ST_SPLIT;
                end
                else if (b_reg.next < NIL)
                begin
                    cur_next = b_reg.next;
                    state_next = ST_RZ_NRD;
                end
                else
                begin
                    cur_next = head_reg;
                    last_next = NIL;
                    steps_next = '0;
                    ret_next = RET_MOVED;
                    state_next = ST_GRANT_RD;
                end
            end
            ST_RZ_NRD:
            begin
                rd_addr = cur_reg[IW-1:0];
                state_next = ST_RZ_NCHK;
            end
            ST_RZ_NCHK:
            begin
                sum = {1'b0, b_reg.size} + {1'b0, HDR} + {1'b0, rd_q.size};
                if (rd_q.free && sum >= {1'b0, s_reg})
                begin
                    used_next[cur_reg[IW-1:0]] = 1'b0;
                    b_next.size = sum[SIZE_W-1:0];
                    b_next.next = rd_q.next;
                    fix_next = rd_q.next;
                    res_next = addr_reg;
                    ok_next = 1'b1;
                    ret_next = RET_RZ_GROW;
                    state_next = ST_ABS_FIX;
                end
                else
                begin
                    cur_next = head_reg;
                    last_next = NIL;
                    steps_next = '0;
                    ret_next = RET_MOVED;
                    state_next = ST_GRANT_RD;
                end
            end
            ST_GRANT_RD:
            begin
                if (cur_reg >= NIL || steps_reg >= (NW+1)'(MAX_BLOCKS))
                begin
                    state_next = ST_GROW;
                end
                else
                begin
                    rd_addr = cur_reg[IW-1:0];
                    state_next = ST_GRANT_CK;
                end
            end
            ST_GRANT_CK:
            begin
                if (rd_q.free && rd_q.size >= s_reg)
                begin
                    b_next = rd_q;
                    b_next.free = 1'b0;
                    bi_next = cur_reg;
                    res_next = rd_q.start + ADDR_W'(HEADER_BYTES);
                    ok_next = 1'b1;
                    state_next = ST_SPLIT;
                end
                else
                begin
                    last_next = cur_reg;
                    cur_next = rd_q.next;
                    steps_next = steps_reg + 1'b1;
                    state_next = ST_GRANT_RD;
                end
            end
            ST_GROW:
            begin
                sum = {1'b0, top_reg} + {1'b0, HDR} + {1'b0, s_reg};
                if (sum > HEAP_LIM || ({1'b0, top_reg} + {1'b0, HDR}) > (SIZE_W+1)'(16'hFFFF)
                    || !slot_avail)
                begin
                    state_next = (ret_reg == RET_MOVED) ? ST_IDLE : ST_OUT;
                    if (ret_reg == RET_MOVED)
                    begin
                        state_next = ST_OUT;
                    end
                end
                else
                begin
                    used_next[free_slot[IW-1:0]] = 1'b1;
                    wr_en = 1'b1;
                    wr_addr = free_slot[IW-1:0];
                    wr_data.start = top_reg[ADDR_W-1:0];
                    wr_data.size = s_reg;
                    wr_data.free = 1'b0;
                    wr_data.next = NIL;
                    wr_data.prev = last_reg;
                    if (last_reg >= NIL)
                    begin
                        head_next = free_slot;
                    end
                    top_next = sum[SIZE_W-1:0];
                    res_next = top_reg[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);
                    ok_next = 1'b1;
                    if (last_reg < NIL)
                    begin
                        cur_next = last_reg;
                        fix_next = free_slot;
                        state_next = ST_SPLIT_NX;
                        b_next.free = 1'b1;
                    end
                    else
                    begin
                        state_next = (ret_reg == RET_MOVED) ? ST_REL_PRD : ST_OUT;
                    end
                    if (ret_reg == RET_MOVED && last_reg >= NIL)
                    begin
                        mv_next = 1'b1;
                        b_next = old_reg;
                        b_next.free = 1'b1;
                        bi_next = oldi_reg;
                        ret_next = RET_REL1;
                    end
                end
            end
            ST_SPLIT:
            begin
                // write b (possibly split) and set up the new remainder entry
                wr_en = 1'b1;
                wr_addr = bi_reg[IW-1:0];
                wr_data = b_reg;
                if (b_reg.size - s_reg >= MINSPLIT && slot_avail)
                begin
                    used_next[free_slot[IW-1:0]] = 1'b1;
                    n_next.start = b_reg.start + ADDR_W'(HEADER_BYTES) + s_reg[ADDR_W-1:0];
                    n_next.size = b_reg.size - s_reg - HDR;
                    n_next.free = 1'b1;
                    n_next.next = b_reg.next;
                    n_next.prev = bi_reg;
                    ni_next = free_slot;
                    wr_data.size = s_reg;
                    wr_data.next = free_slot;
                    b_next.size = s_reg;
                    b_next.next = free_slot;
                    cur_next = '0;
                    state_next = ST_SPLIT_NX;
                    fix_next = NIL;
                end
                else
                begin
                    state_next = (ret_reg == RET_MOVED) ? ST_REL_PRD : ST_OUT;
                    if (ret_reg == RET_MOVED)
                    begin
                        mv_next = 1'b1;
                        b_next = old_reg;
                        b_next.free = 1'b1;
                        bi_next = oldi_reg;
                        ret_next = RET_REL1;
                    end
                end
            end
            ST_SPLIT_NX:
            begin
                // fix_reg == NIL: write remainder then fix successor prev
                // fix_reg != NIL: patch next pointer of last_reg after growth
                if (fix_reg != NIL)
                begin
                    rd_addr = last_reg[IW-1:0];
                    state_next = ST_TRIM_RD;
                    cur_next = NIL;
                end
                else
                begin
                    wr_en = 1'b1;
                    wr_addr = ni_reg[IW-1:0];
                    wr_data = n_reg;
                    if (n_reg.next < NIL)
                    begin
                        fix_next = n_reg.next;
                        bi_next = ni_reg;
                        rd_addr = n_reg.next[IW-1:0];
                        cur_next = n_reg.next;
                        state_next = ST_REL_NX;
                        b_next.free = 1'b0;
                        steps_next = '0;
                    end
                    else
                    begin
                        state_next = (ret_reg == RET_MOVED) ? ST_REL_PRD : ST_OUT;
                        if (ret_reg == RET_MOVED)
                        begin
                            mv_next = 1'b1;
                            b_next = old_reg;
                            b_next.free = 1'b1;
                            bi_next = oldi_reg;
                            ret_next = RET_REL1;
                        end
                    end
                end
            end
            ST_REL_NX:
            begin
                // read-modify-write: set prev of entry cur_reg to bi_reg
                wr_en = 1'b1;
                wr_addr = cur_reg[IW-1:0];
                wr_data = rd_q;
                wr_data.prev = bi_reg;
                if (ret_reg == RET_RZ_GROW)
                begin
                    ret_next = RET_RZ_SHRINK;
                    state_next = ST_SPLIT;
                end
                else if (steps_reg == '0)
                begin
                    state_next = (ret_reg == RET_MOVED) ? ST_REL_PRD : ST_OUT;
                    if (ret_reg == RET_MOVED)
                    begin
                        mv_next = 1'b1;
                        b_next = old_reg;
                        b_next.free = 1'b1;
                        bi_next = oldi_reg;
                        ret_next = RET_REL1;
                    end
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_TRIM_RD:
            begin
                if (cur_reg == NIL)
                begin
                    // after growth: patch last's next
                    wr_en = 1'b1;
                    wr_addr = last_reg[IW-1:0];
                    wr_data = rd_q;
                    wr_data.next = fix_reg;
                    state_next = (ret_reg == RET_MOVED) ? ST_REL_PRD : ST_OUT;
                    if (ret_reg == RET_MOVED)
                    begin
                        mv_next = 1'b1;
                        b_next = old_reg;
                        b_next.free = 1'b1;
                        bi_next = oldi_reg;
                        ret_next = RET_REL1;
                    end
                end
                else
                begin
                    // release trim: clear next of prev
                    wr_en = 1'b1;
                    wr_addr = cur_reg[IW-1:0];
                    wr_data = rd_q;
                    wr_data.next = NIL;
                    state_next = ST_OUT;
                end
            end
            ST_REL_PRD:
            begin
                // b_reg holds the block being released (free set), re-read it
                // since growth or split may have rewritten its links
                rd_addr = bi_reg[IW-1:0];
                state_next = ST_REL_PCK;
                steps_next = '0;
            end
            ST_REL_PCK:
            begin
                if (steps_reg == '0)
                begin
                    b_next = rd_q;
                    b_next.free = 1'b1;
                    if (rd_q.prev < NIL)
                    begin
                        rd_addr = rd_q.prev[IW-1:0];
                        steps_next = (NW+1)'(1);
                    end
                    else
                    begin
                        state_next = ST_REL_ABS;
                    end
                end
                else
                begin
                    if (rd_q.free)
                    begin
                        // merge b into prev
                        wr_en = 1'b1;
                        wr_addr = bi_reg[IW-1:0];
                        wr_data = b_reg;
                        n_next = b_reg;
                        ni_next = bi_reg;
                        bi_next = b_reg.prev;
                        b_next = rd_q;
                        b_next.size = rd_q.size + HDR + b_reg.size;
                        b_next.next = b_reg.next;
                        used_next[bi_reg[IW-1:0]] = 1'b0;
                        if (b_reg.next < NIL)
                        begin
                            cur_next = b_reg.next;
                            fix_next = b_reg.next;
                            ret_next = RET_REL2;
                            state_next = ST_ABS_FIX;
                        end
                        else
                        begin
                            state_next = ST_REL_ABS;
                        end
                    end
                    else
                    begin
                        state_next = ST_REL_ABS;
                    end
                end
            end
            ST_REL_ABS:
            begin
                wr_en = 1'b1;
                wr_addr = bi_reg[IW-1:0];
                wr_data = b_reg;
                if (b_reg.next < NIL)
                begin
                    cur_next = b_reg.next;
                    state_next = ST_ABS_RD;
                end
                else
                begin
                    top_next = {1'b0, b_reg.start};
                    used_next[bi_reg[IW-1:0]] = 1'b0;
                    if (b_reg.prev < NIL)
                    begin
                        cur_next = b_reg.prev;
                        state_next = ST_TRIM;
                    end
                    else
                    begin
                        head_next = NIL;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_TRIM:
            begin
                rd_addr = cur_reg[IW-1:0];
                state_next = ST_TRIM_RD;
            end
            ST_ABS_RD:
            begin
                rd_addr = cur_reg[IW-1:0];
                state_next = ST_ABS_CK;
            end
            ST_ABS_CK:
            begin
                if (rd_q.free)
                begin
                    used_next[cur_reg[IW-1:0]] = 1'b0;
                    b_next.size = b_reg.size + HDR + rd_q.size;
                    b_next.next = rd_q.next;
                    fix_next = rd_q.next;
                    ret_next = RET_REL1;
                    state_next = ST_ABS_FIX;
                end
                else
                begin
                    // point the successor back at the surviving block
                    wr_en = 1'b1;
                    wr_addr = cur_reg[IW-1:0];
                    wr_data = rd_q;
                    wr_data.prev = bi_reg;
                    state_next = ST_OUT;
                end
            end
            ST_ABS_FIX:
            begin
                wr_en = 1'b1;
                wr_addr = bi_reg[IW-1:0];
                wr_data = b_reg;
                if (ret_reg == RET_REL2)
                begin
                    // prev merge done; now absorb b's old successor if free
                    state_next = ST_ABS_RD;
                    cur_next = b_reg.next;
                    ret_next = RET_REL1;
                    // successor's prev still points at merged slot; patched below
                    if (b_reg.next < NIL)
                    begin
                        state_next = ST_ABS_RD;
                    end
                end
                else if (fix_reg < NIL)
                begin
                    cur_next = fix_reg;
                    rd_addr = fix_reg[IW-1:0];
                    steps_next = (ret_reg == RET_RZ_GROW) ? (NW+1)'(0) : (NW+1)'(1);
                    state_next = ST_REL_NX;
                end
                else
                begin
                    state_next = (ret_reg == RET_RZ_GROW) ? ST_SPLIT : ST_OUT;
                    ret_next = (ret_reg == RET_RZ_GROW) ? RET_RZ_SHRINK : ret_reg;
                end
            end
            ST_OUT:
            begin
                if (!ov_reg)
                begin
                    ov_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            used_reg <= '0;
            head_reg <= NIL;
            top_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg <= used_next;
            head_reg <= head_next;
            top_reg <= top_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ret_reg <= ret_next;
        act_reg <= act_next;
        addr_reg <= addr_next;
        s_reg <= s_next;
        cur_reg <= cur_next;
        last_reg <= last_next;
        steps_reg <= steps_next;
        b_reg <= b_next;
        n_reg <= n_next;
        bi_reg <= bi_next;
        ni_reg <= ni_next;
        oldi_reg <= oldi_next;
        old_reg <= old_next;
        fix_reg <= fix_next;
        res_reg <= res_next;
        ok_reg <= ok_next;
        mv_reg <= mv_next;
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import ffba_pkg::*;

    localparam int HDR      = 20;
    localparam int HEAP     = 65536;
    localparam int SLOTS    = 64;
    localparam logic [6:0] NIL = 7'd64;
    localparam int N_RANDOM = 1530;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [15:0] addr;
        logic        ok;
        logic        moved;
    } reply_t;

    typedef struct {
        action_t     act;
        logic [15:0] addr;
        logic [15:0] size;
        bit          typed;
        reply_t      want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // action, address, size, zero fill
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // result_address, ok, moved, zero fill

    first_fit_block_allocator uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // allocator shadow state
    logic [15:0] blk_start [SLOTS];
    logic [16:0] blk_size  [SLOTS];
    bit          blk_free  [SLOTS];
    logic [6:0]  blk_next  [SLOTS];
    logic [6:0]  blk_prev  [SLOTS];
    bit          slot_busy [SLOTS];
    logic [6:0]  chain_head;
    logic [16:0] heap_top;

    reply_t      pending_replies[$];
    logic [15:0] live_addrs[$];
    int          error_count = 0;
    int          send_idle_pct = 32;
    int          recv_idle_pct = 88;
    logic        recv_hold = 1'b0;
    bit          hold_request = 1'b0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic logic [6:0] claim_slot();
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!slot_busy[i])
            begin
                slot_busy[i] = 1'b1;
                return 7'(i);
            end
        end
        return NIL;
    endfunction

    function automatic void carve_block(logic [6:0] b, logic [16:0] s);
        logic [6:0] n;
        n = claim_slot();
        if (n == NIL)
            return;
        blk_start[n] = 16'(blk_start[b] + HDR + s);
        blk_size[n]  = 17'(blk_size[b] - s - HDR);
        blk_free[n]  = 1'b1;
        blk_next[n]  = blk_next[b];
        blk_prev[n]  = b;
        blk_size[b]  = s;
        blk_next[b]  = n;
        if (blk_next[n] != NIL)
            blk_prev[blk_next[n]] = n;
    endfunction

    function automatic void merge_next(logic [6:0] b);
        logic [6:0] n;
        n = blk_next[b];
        if (n != NIL && blk_free[n])
        begin
            blk_size[b] = 17'(blk_size[b] + HDR + blk_size[n]);
            slot_busy[n] = 1'b0;
            blk_next[b] = blk_next[n];
            if (blk_next[b] != NIL)
                blk_prev[blk_next[b]] = b;
        end
    endfunction

    function automatic bit first_fit(logic [16:0] s, output logic [15:0] got);
        logic [6:0] b;
        logic [6:0] last;
        logic [6:0] n;
        int steps;
        b = chain_head;
        last = NIL;
        steps = 0;
        got = '0;
        while (b != NIL && steps < SLOTS)
        begin
            if (blk_free[b] && blk_size[b] >= s)
            begin
                if (32'(blk_size[b]) - 32'(s) >= HDR + 4)
                    carve_block(b, s);
                blk_free[b] = 1'b0;
                got = 16'(blk_start[b] + HDR);
                return 1'b1;
            end
            last = b;
            b = blk_next[b];
            steps++;
        end
        if (32'(heap_top) + HDR + 32'(s) > HEAP)
            return 1'b0;
        if (32'(heap_top) + HDR > 32'hFFFF)
            return 1'b0;
        n = claim_slot();
        if (n == NIL)
            return 1'b0;
        blk_start[n] = 16'(heap_top);
        blk_size[n]  = s;
        blk_free[n]  = 1'b0;
        blk_next[n]  = NIL;
        blk_prev[n]  = last;
        if (last != NIL)
            blk_next[last] = n;
        else
            chain_head = n;
        heap_top = 17'(heap_top + HDR + s);
        got = 16'(blk_start[n] + HDR);
        return 1'b1;
    endfunction

    function automatic logic [6:0] find_live(logic [15:0] a);
        logic [6:0] b;
        int steps;
        b = chain_head;
        steps = 0;
        if (a == 16'd0)
            return NIL;
        while (b != NIL && steps < SLOTS)
        begin
            if (32'(blk_start[b]) + HDR == 32'(a))
                return blk_free[b] ? NIL : b;
            b = blk_next[b];
            steps++;
        end
        return NIL;
    endfunction

    function automatic void free_block(logic [6:0] blk);
        logic [6:0] b;
        logic [6:0] p;
        b = blk;
        blk_free[b] = 1'b1;
        p = blk_prev[b];
        if (p != NIL && blk_free[p])
        begin
            merge_next(p);
            b = p;
        end
        if (blk_next[b] != NIL)
            merge_next(b);
        else
        begin
            p = blk_prev[b];
            if (p != NIL)
                blk_next[p] = NIL;
            else
                chain_head = NIL;
            heap_top = 17'(blk_start[b]);
            slot_busy[b] = 1'b0;
        end
    endfunction

    function automatic reply_t predict_reply(action_t act, logic [15:0] a, logic [15:0] size);
        reply_t r;
        logic [16:0] s;
        logic [15:0] got;
        logic [6:0] b;
        logic [6:0] n;
        r = '0;
        s = (17'(size) + 17'd3) & ~17'd3;
        case (act)
            ACT_ALLOC:
            begin
                if (first_fit(s, got))
                    r = '{got, 1'b1, 1'b0};
            end
            ACT_RELEASE:
            begin
                b = find_live(a);
                if (b != NIL)
                begin
                    free_block(b);
                    r.ok = 1'b1;
                end
            end
            ACT_RESIZE:
            begin
                if (a == 16'd0)
                begin
                    if (first_fit(s, got))
                        r = '{got, 1'b1, 1'b0};
                end
                else
                begin
                    b = find_live(a);
                    if (b != NIL)
                    begin
                        n = blk_next[b];
                        if (blk_size[b] >= s)
                        begin
                            if (32'(blk_size[b]) - 32'(s) >= HDR + 4)
                                carve_block(b, s);
                            r = '{a, 1'b1, 1'b0};
                        end
                        else if (n != NIL && blk_free[n] &&
                                 32'(blk_size[b]) + HDR + 32'(blk_size[n]) >= 32'(s))
                        begin
                            merge_next(b);
                            if (32'(blk_size[b]) - 32'(s) >= HDR + 4)
                                carve_block(b, s);
                            r = '{a, 1'b1, 1'b0};
                        end
                        else if (first_fit(s, got))
                        begin
                            free_block(b);
                            r = '{got, 1'b1, 1'b1};
                        end
                    end
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic void track_live(action_t act, logic [15:0] a, reply_t r);
        if (!r.ok)
            return;
        if (act == ACT_ALLOC || (act == ACT_RESIZE && a == 16'd0))
            live_addrs.push_back(r.addr);
        else if (act == ACT_RELEASE || (act == ACT_RESIZE && r.moved))
        begin
            foreach (live_addrs[i])
            begin
                if (live_addrs[i] == a)
                begin
                    live_addrs.delete(i);
                    break;
                end
            end
            if (r.moved)
                live_addrs.push_back(r.addr);
        end
    endfunction

    task automatic send_item(input action_t act, input logic [15:0] a,
                             input logic [15:0] size, input bit typed, input reply_t want);
        reply_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, size, a, act};
        do
            @(posedge clk);
        while (!s_axis_tready);
        r = predict_reply(act, a, size);
        pending_replies.push_back(typed ? want : r);
        track_live(act, a, r);
    endtask

    always @(posedge clk)
    begin
        m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin
        wait (hold_request);
        @(posedge clk);
        recv_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        recv_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        reply_t got;
        reply_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = '{m_axis_tdata[15:0], m_axis_tdata[16], m_axis_tdata[17]};
            if (pending_replies.size() == 0)
                report_mismatch("unexpected item, result_address", got.addr, -1);
            else
            begin
                want = pending_replies.pop_front();
                if (got.addr !== want.addr)
                    report_mismatch("result_address", got.addr, want.addr);
                if (got.ok !== want.ok)
                    report_mismatch("ok", got.ok, want.ok);
                if (got.moved !== want.moved)
                    report_mismatch("moved", got.moved, want.moved);
            end
        end
    end

    initial
    begin
        #50ms;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        dir_row_t   rows[$];
        action_t    act;
        logic [15:0] a;
        logic [15:0] size;
        int pick;
        int phase_len;

        chain_head = NIL;
        heap_top   = '0;
        foreach (slot_busy[i])
            slot_busy[i] = 1'b0;

        rows.push_back('{ACT_ALLOC,   16'd0,     16'd0,     1, '{16'd20, 1'b1, 1'b0}});
        rows.push_back('{ACT_ALLOC,   16'd0,     16'd1,     1, '{16'd40, 1'b1, 1'b0}});
        rows.push_back('{ACT_RELEASE, 16'd0,     16'd0,     1, '{16'd0, 1'b0, 1'b0}});
        rows.push_back('{ACT_NONE,    16'hFFFF,  16'hFFFF,  1, '{16'd0, 1'b0, 1'b0}});
        rows.push_back('{ACT_RELEASE, 16'd40,    16'd0,     1, '{16'd0, 1'b1, 1'b0}});
        rows.push_back('{ACT_ALLOC,   16'hFFFF,  16'hFFFF,  1, '{16'd0, 1'b0, 1'b0}});
        rows.push_back('{ACT_RELEASE, 16'd12345, 16'd0,     1, '{16'd0, 1'b0, 1'b0}});
        rows.push_back('{ACT_RESIZE,  16'd0,     16'd8,     1, '{16'd40, 1'b1, 1'b0}});
        rows.push_back('{ACT_RESIZE,  16'd40,    16'd100,   0, '0});
        rows.push_back('{ACT_ALLOC,   16'd0,     16'd200,   0, '0});
        rows.push_back('{ACT_ALLOC,   16'd0,     16'd64,    0, '0});
        rows.push_back('{ACT_RESIZE,  16'd68,    16'd4,     0, '0});
        rows.push_back('{ACT_RESIZE,  16'd68,    16'd60,    0, '0});
        rows.push_back('{ACT_RELEASE, 16'd20,    16'd0,     0, '0});
        rows.push_back('{ACT_RELEASE, 16'd20,    16'd0,     0, '0});
        rows.push_back('{ACT_RESIZE,  16'd20,    16'd4,     0, '0});
        rows.push_back('{ACT_ALLOC,   16'd0,     16'd65000, 0, '0});
        rows.push_back('{ACT_ALLOC,   16'd0,     16'd60000, 0, '0});
        rows.push_back('{ACT_RESIZE,  16'd0,     16'd3,     0, '0});
        rows.push_back('{ACT_RELEASE, 16'hAAAA,  16'h5555,  0, '0});
        rows.push_back('{ACT_RESIZE,  16'h5555,  16'hAAAA,  0, '0});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_item(rows[i].act, rows[i].addr, rows[i].size, rows[i].typed, rows[i].want);

        phase_len = N_RANDOM / 3;
        for (int k = 0; k < N_RANDOM; k++)
        begin
            if (k == phase_len)
            begin
                send_idle_pct = 88;
                recv_idle_pct = 32;
            end
            if (k == 2 * phase_len)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_request = 1'b1;
            end
            pick = $urandom_range(99);
            case ($urandom_range(19))
                0:       size = 16'($urandom_range(65535));
                1, 2, 3: size = 16'($urandom_range(3000));
                default: size = 16'($urandom_range(160));
            endcase
            a = '0;
            if (live_addrs.size() < 8 || pick < 42)
                act = ACT_ALLOC;
            else if (pick < 76)
            begin
                act = ACT_RELEASE;
                a = live_addrs[$urandom_range(live_addrs.size() - 1)];
            end
            else if (pick < 90)
            begin
                act = ACT_RESIZE;
                a = live_addrs[$urandom_range(live_addrs.size() - 1)];
            end
            else if (pick < 93)
                act = ACT_RESIZE;
            else
            begin
                act = action_t'($urandom_range(3));
                a = 16'($urandom_range(65535));
            end
            send_item(act, a, size, 0, '0);
        end
        s_axis_tvalid <= 1'b0;

        wait (pending_replies.size() == 0);
        repeat (300) @(posedge clk);
        if (error_count == 0 && pending_replies.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
